@@ hw/rtl/msvf_pkg.sv @@
// Types, register indexes and saturation helpers for the multichannel state variable filter.
package msvf_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int STATE_W   = 40;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 26;
    localparam int V3_W      = 42;
    localparam int ACC_W     = 50;
    localparam int Q_W       = 49;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BAND_IN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BAND_FB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW_IN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW_BAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 3'd5;

    localparam logic signed [COEF_W-1:0] DAMPING_RESET = 32'sd67108864;

    localparam logic signed [ACC_W-1:0] STATE_MAX = 50'sd549755813887;
    localparam logic signed [ACC_W-1:0] STATE_MIN = -50'sd549755813888;
    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 50'sd8388607;
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -50'sd8388608;

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_BANDPASS = 2'd1,
        MODE_HIGHPASS = 2'd2,
        MODE_NOTCH    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DRAIN,
        S_SAT,
        S_KMUL,
        S_KACC,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_G1,
        OP_G2,
        OP_G3,
        OP_G4,
        OP_K
    } mul_op_t;

    typedef struct packed {
        logic [2:0]                 channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                 channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } out_word_t;

    typedef struct packed {
        logic signed [STATE_W-1:0]  band;
        logic signed [STATE_W-1:0]  low;
        logic signed [SAMPLE_W-1:0] prev;
    } entry_t;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > STATE_MAX) begin
            r = STATE_MAX[STATE_W-1:0];
        end else if (v < STATE_MIN) begin
            r = STATE_MIN[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAMPLE_MAX) begin
            r = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (v < SAMPLE_MIN) begin
            r = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/multichannel_state_variable_filter.sv @@
// Multichannel state variable filter: per-channel state memory, shared multiplier, sequencer.
//
//   port group    dir   handshake              word
//   s_*           in    s_valid / s_ready      in_word_t  (channel, sample_in)
//   m_*           out   m_valid / m_ready      out_word_t (channel_out, sample_out)
//   cfg_*         in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A new word is accepted only in the idle state, once the last word is through. Four
// coefficient products (lowpass, bandpass), five for highpass and notch, go through one shared
// 32x27 / 32x16 multiplier pair, one product per cycle. A channel beyond the state
// memory skips the memory and the multiplier. Reset clears the per-entry valid bits, so state reads as zero
// at once. A stalled m_ready holds the finished word in the sequencer's final state, S_DONE.
module multichannel_state_variable_filter #(
    parameter int CHANNELS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  msvf_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output msvf_pkg::out_word_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msvf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msvf_pkg::COEF_W-1:0]     cfg_data
);
    import msvf_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t                     state_reg, state_next;
    mul_op_t                    op_reg, op_next;

    mode_t                      mode_reg;
    logic signed [COEF_W-1:0]   g1_reg, g2_reg, g3_reg, g4_reg, k_reg;

    entry_t                     mem [CHANNELS];
    logic [CHANNELS-1:0]        valid_reg;
    entry_t                     rd_reg;
    logic                       rdv_reg;
    entry_t                     entry_old;

    logic [2:0]                 chan_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_in;
    logic                       in_range;
    logic                       oor_reg;
    logic signed [SAMPLE_W-1:0] smp_reg;

    logic signed [V3_W-1:0]     xs42, prev42, low2, v3_next;
    logic signed [V3_W-1:0]     v3_reg;
    logic signed [STATE_W-1:0]  bold_reg;
    logic signed [ACC_W-1:0]    acc_band_reg, acc_low_reg, acc_y_reg;
    logic signed [STATE_W-1:0]  bnew_reg, lnew_reg, bnew_c, lnew_c;
    logic signed [ACC_W-1:0]    xs50;

    logic                       mul_go;
    mul_op_t                    mul_tag;
    logic signed [COEF_W-1:0]   mul_c;
    logic signed [V3_W-1:0]     mul_x;
    logic signed [15:0]         mul_hi;
    logic signed [26:0]         mul_lo;
    logic signed [47:0]         p_hi_next, p_hi_reg;
    logic signed [58:0]         p_lo_next, p_lo_reg;
    logic                       pv_reg;
    mul_op_t                    ptag_reg;
    logic signed [Q_W-1:0]      q;

    logic signed [ACC_W-1:0]    y50, ysh;
    logic                       accept, out_free;
    out_word_t                  m_data_reg;
    logic                       m_valid_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign idx_in   = IDX_W'(s_data.channel);
    assign in_range = int'(s_data.channel) < CHANNELS;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LOWPASS;
            g1_reg   <= '0;
            g2_reg   <= '0;
            g3_reg   <= '0;
            g4_reg   <= '0;
            k_reg    <= DAMPING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE:          mode_reg <= mode_t'(cfg_data[1:0]);
                REG_COEF_BAND_IN:  g1_reg   <= cfg_data;
                REG_COEF_BAND_FB:  g2_reg   <= cfg_data;
                REG_COEF_LOW_IN:   g3_reg   <= cfg_data;
                REG_COEF_LOW_BAND: g4_reg   <= cfg_data;
                REG_DAMPING:       k_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_G1;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = in_range ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                state_next = S_MUL;
                op_next    = OP_G1;
            end
            S_MUL: begin
                if (op_reg == OP_G4) begin
                    state_next = S_DRAIN;
                end else begin
                    op_next = mul_op_t'(op_reg + 3'd1);
                end
            end
            S_DRAIN: state_next = S_SAT;
            S_SAT: begin
                if (mode_reg == MODE_HIGHPASS || mode_reg == MODE_NOTCH) begin
                    state_next = S_KMUL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_KMUL: state_next = S_KACC;
            S_KACC: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state memory
    assign entry_old = rdv_reg ? rd_reg : '0;
    assign bnew_c    = sat_state(acc_band_reg);
    assign lnew_c    = sat_state(acc_low_reg);

    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            rd_reg <= mem[idx_in];
        end
        if (state_reg == S_SAT) begin
            mem[idx_reg] <= '{band: bnew_c, low: lnew_c, prev: smp_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (state_reg == S_SAT) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // operand set-up
    assign xs42    = {{10{smp_reg[SAMPLE_W-1]}}, smp_reg, 8'b0};
    assign prev42  = {{10{entry_old.prev[SAMPLE_W-1]}}, entry_old.prev, 8'b0};
    assign low2    = {entry_old.low[STATE_W-1], entry_old.low, 1'b0};
    assign v3_next = xs42 + prev42 - low2;
    assign xs50    = ACC_W'(xs42);

    // shared multiplier: coef * x split at the binary point of the coefficient
    always_comb begin
        mul_go  = 1'b0;
        mul_tag = OP_K;
        mul_c   = k_reg;
        mul_x   = V3_W'(bnew_reg);
        if (state_reg == S_MUL) begin
            mul_go  = 1'b1;
            mul_tag = op_reg;
            case (op_reg)
                OP_G1: begin
                    mul_c = g1_reg;
                    mul_x = v3_reg;
                end
                OP_G2: begin
                    mul_c = g2_reg;
                    mul_x = V3_W'(bold_reg);
                end
                OP_G3: begin
                    mul_c = g3_reg;
                    mul_x = v3_reg;
                end
                default: begin
                    mul_c = g4_reg;
                    mul_x = V3_W'(bold_reg);
                end
            endcase
        end else if (state_reg == S_KMUL) begin
            mul_go = 1'b1;
        end
    end

    assign mul_hi    = mul_x[V3_W-1:COEF_FRAC];
    assign mul_lo    = {1'b0, mul_x[COEF_FRAC-1:0]};
    assign p_hi_next = mul_c * mul_hi;
    assign p_lo_next = mul_c * mul_lo;
    assign q         = Q_W'(p_hi_reg) + Q_W'(p_lo_reg >>> COEF_FRAC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= mul_go;
        end
    end

    always_ff @(posedge aclk) begin
        p_hi_reg <= p_hi_next;
        p_lo_reg <= p_lo_next;
        ptag_reg <= mul_tag;
        if (accept) begin
            chan_reg <= s_data.channel;
            smp_reg  <= s_data.sample_in;
            idx_reg  <= idx_in;
            oor_reg  <= !in_range;
            rdv_reg  <= in_range && valid_reg[idx_in];
        end
        if (state_reg == S_READ) begin
            v3_reg       <= v3_next;
            bold_reg     <= entry_old.band;
            acc_band_reg <= ACC_W'(entry_old.band);
            acc_low_reg  <= ACC_W'(entry_old.low);
        end else if (pv_reg) begin
            case (ptag_reg)
                OP_G1:   acc_band_reg <= acc_band_reg + ACC_W'(q);
                OP_G2:   acc_band_reg <= acc_band_reg - ACC_W'(q);
                OP_G3:   acc_low_reg  <= acc_low_reg + ACC_W'(q);
                OP_G4:   acc_low_reg  <= acc_low_reg + ACC_W'(q);
                default: acc_y_reg    <= acc_y_reg - ACC_W'(q);
            endcase
        end
        if (state_reg == S_SAT) begin
            bnew_reg <= bnew_c;
            lnew_reg <= lnew_c;
            if (mode_reg == MODE_HIGHPASS) begin
                acc_y_reg <= xs50 - ACC_W'(lnew_c);
            end else begin
                acc_y_reg <= xs50;
            end
        end
    end

    // output word
    always_comb begin
        case (mode_reg)
            MODE_LOWPASS:  y50 = ACC_W'(lnew_reg);
            MODE_BANDPASS: y50 = ACC_W'(bnew_reg);
            default:       y50 = acc_y_reg;
        endcase
        ysh = y50 >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.channel_out <= chan_reg;
            m_data_reg.sample_out  <= oor_reg ? '0 : sat_sample(ysh);
        end
    end

endmodule

@@ tb/multichannel_state_variable_filter_tb.sv @@
// Self-checking testbench for the multichannel state variable filter: random words and settings.
module multichannel_state_variable_filter_tb;
    import msvf_pkg::*;

    localparam int NUM_CH = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_FULL = 24'h7f_ffff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_FULL = 24'h80_0000;
    localparam logic [COEF_W-1:0] COEF_POS_FULL = 32'h7fff_ffff;
    localparam logic [COEF_W-1:0] COEF_NEG_FULL = 32'h8000_0000;
    localparam int SETTLE_CYCLES = 16;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        errors = 0;
    int        gap_max = 0;
    int        stall_max = 0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        stall_left = 0;

    // filter settings and per-channel state as the block should hold them
    mode_t              mode_q = MODE_LOWPASS;
    logic signed [31:0] g_band_in = '0;
    logic signed [31:0] g_band_fb = '0;
    logic signed [31:0] g_low_in = '0;
    logic signed [31:0] g_low_band = '0;
    logic signed [31:0] k_damp = DAMPING_RESET;
    longint             band_q[NUM_CH];
    longint             low_q[NUM_CH];
    longint             prev_q[NUM_CH];

    multichannel_state_variable_filter #(
        .CHANNELS(NUM_CH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // floor(c * x / 2^26), exact
    function automatic longint coef_product(input logic signed [31:0] c, input longint x);
        logic signed [95:0] p;
        p = c * x;
        p = p >>> COEF_FRAC;
        return longint'(p[63:0]);
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint top;
        longint bot;
        top = (longint'(1) <<< (w - 1)) - 1;
        bot = -(longint'(1) <<< (w - 1));
        if (v > top) begin
            return top;
        end
        if (v < bot) begin
            return bot;
        end
        return v;
    endfunction

    function automatic out_word_t svf_predict(input in_word_t w);
        out_word_t r;
        int        ch;
        longint    xs;
        longint    v3;
        longint    band_old;
        longint    band_new;
        longint    low_new;
        longint    y;
        ch = int'(w.channel);
        xs = longint'(w.sample_in);
        xs = xs * 256;
        band_old = band_q[ch];
        v3 = xs + prev_q[ch] * 256 - 2 * low_q[ch];
        band_new = clamp(band_old + coef_product(g_band_in, v3)
                         - coef_product(g_band_fb, band_old), STATE_W);
        low_new = clamp(low_q[ch] + coef_product(g_low_in, v3)
                        + coef_product(g_low_band, band_old), STATE_W);
        band_q[ch] = band_new;
        low_q[ch] = low_new;
        prev_q[ch] = longint'(w.sample_in);
        case (mode_q)
            MODE_LOWPASS: begin
                y = low_new;
            end
            MODE_BANDPASS: begin
                y = band_new;
            end
            MODE_HIGHPASS: begin
                y = xs - coef_product(k_damp, band_new) - low_new;
            end
            default: begin
                y = xs - coef_product(k_damp, band_new);
            end
        endcase
        y = clamp(y >>> 8, SAMPLE_W);
        r.channel_out = w.channel;
        r.sample_out = y[SAMPLE_W-1:0];
        return r;
    endfunction

    // sender: bursts of words separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_words.push_back(svf_predict(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_words.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(20);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word against the oldest prediction
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got channel %0d sample %0d",
                         $time, m_data.channel_out, m_data.sample_out);
            end else begin
                want = expected_words.pop_front();
                if (m_data.channel_out !== want.channel_out) begin
                    errors++;
                    $display("%0t: channel_out expected %0d, got %0d",
                             $time, want.channel_out, m_data.channel_out);
                end
                if (m_data.sample_out !== want.sample_out) begin
                    errors++;
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, want.sample_out, m_data.sample_out);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (stall_max > 0 && $urandom_range(3) == 0) begin
                stall_left = $urandom_range(1, stall_max);
            end
        end
    end

    // leaves cfg_valid high; wait_idle lowers it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODE: begin
                mode_q = mode_t'(d[1:0]);
            end
            REG_COEF_BAND_IN: begin
                g_band_in = d;
            end
            REG_COEF_BAND_FB: begin
                g_band_fb = d;
            end
            REG_COEF_LOW_IN: begin
                g_low_in = d;
            end
            REG_COEF_LOW_BAND: begin
                g_low_band = d;
            end
            REG_DAMPING: begin
                k_damp = d;
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        cfg_valid <= 1'b0;
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_word(input logic [2:0] ch, input logic [SAMPLE_W-1:0] smp);
        in_word_t w;
        w.channel = ch;
        w.sample_in = smp;
        pending_words.push_back(w);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] mag;
        case ($urandom_range(9))
            0: begin
                return COEF_POS_FULL;
            end
            1: begin
                return COEF_NEG_FULL;
            end
            2: begin
                return '0;
            end
            3: begin
                return $urandom();
            end
            default: begin
                mag = $urandom_range($urandom_range(1) ? 32'h0400_0000 : 32'h0040_0000);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] mag;
        case ($urandom_range(9))
            0: begin
                return SAMPLE_POS_FULL;
            end
            1: begin
                return SAMPLE_NEG_FULL;
            end
            2, 3, 4: begin
                return SAMPLE_W'($urandom());
            end
            default: begin
                mag = SAMPLE_W'($urandom_range(24'h01_0000));
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic random_setup();
        case ($urandom_range(2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 12;
        endcase
        case ($urandom_range(2))
            0: stall_max = 0;
            1: stall_max = 4;
            default: stall_max = 8;
        endcase
        write_register(REG_MODE, $urandom());
        if ($urandom_range(1)) begin
            write_register(REG_COEF_BAND_IN, pick_coef());
        end
        if ($urandom_range(1)) begin
            write_register(REG_COEF_BAND_FB, pick_coef());
        end
        if ($urandom_range(1)) begin
            write_register(REG_COEF_LOW_IN, pick_coef());
        end
        if ($urandom_range(1)) begin
            write_register(REG_COEF_LOW_BAND, pick_coef());
        end
        if ($urandom_range(1)) begin
            write_register(REG_DAMPING, pick_coef());
        end
        if ($urandom_range(3) == 0) begin
            write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
        end
    endtask

    initial begin
        mode_t md;
        for (int i = 0; i < NUM_CH; i++) begin
            band_q[i] = 0;
            low_q[i] = 0;
            prev_q[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings
        push_word(3'd0, SAMPLE_POS_FULL);
        push_word(3'd7, SAMPLE_NEG_FULL);
        wait_idle();

        // moderate filter, each output mode in turn
        write_register(REG_COEF_BAND_IN, 32'd13421773);
        write_register(REG_COEF_BAND_FB, 32'd3355443);
        write_register(REG_COEF_LOW_IN, 32'd3355443);
        write_register(REG_COEF_LOW_BAND, 32'd13421773);
        write_register(REG_DAMPING, 32'd93952410);
        write_register(REG_SPARE_A, $urandom());
        write_register(REG_SPARE_B, $urandom());
        md = md.first();
        repeat (4) begin
            write_register(REG_MODE, 32'(md));
            push_word(3'(md), SAMPLE_POS_FULL);
            push_word(3'(md), SAMPLE_NEG_FULL);
            push_word(3'(md) + 3'd4, '0);
            push_word(3'(md) + 3'd4, '1);
            wait_idle();
            gap_max = 3;
            stall_max = 4;
            md = md.next();
        end

        // full-scale coefficients drive state and output into saturation
        write_register(REG_COEF_BAND_IN, COEF_POS_FULL);
        write_register(REG_COEF_BAND_FB, COEF_NEG_FULL);
        write_register(REG_COEF_LOW_IN, COEF_POS_FULL);
        write_register(REG_COEF_LOW_BAND, COEF_NEG_FULL);
        write_register(REG_DAMPING, COEF_NEG_FULL);
        write_register(REG_MODE, 32'(MODE_HIGHPASS));
        repeat (3) begin
            push_word(3'd5, SAMPLE_POS_FULL);
            push_word(3'd5, SAMPLE_NEG_FULL);
        end
        wait_idle();

        repeat (18) begin
            random_setup();
            repeat (75) begin
                push_word(3'($urandom_range(NUM_CH - 1)), pick_sample());
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("multichannel_state_variable_filter test passed");
        end else begin
            $display("multichannel_state_variable_filter test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("multichannel_state_variable_filter test failed");
        $finish;
    end

endmodule
